// File: design/bdq_pkg.sv
// package for the bounded deque: sizes, operation and status codes, cell control struct
// no dependencies; used by bdq_cell and bounded_deque_top
`default_nettype none

package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// field widths fixed by the stream format
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                  shift_r;  // push front: row moves toward the back
		logic                  shift_l;  // pop front: row moves toward the front
		logic                  push_b;   // first free cell takes the word
		logic                  pop_b;    // last held cell lets go
		logic [DATA_WIDTH-1:0] word;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: design/bdq_cell.sv
// one storage cell of the deque row: a word and an occupied flag
// talks to its two neighbors only; uses bdq_pkg
`default_nettype none

module bdq_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bdq_pkg::cell_ctl_t            ctl,
	input  wire logic [bdq_pkg::DATA_WIDTH-1:0] prev_data,
	input  wire logic                          prev_valid,
	input  wire logic [bdq_pkg::DATA_WIDTH-1:0] next_data,
	input  wire logic                          next_valid,
	output logic      [bdq_pkg::DATA_WIDTH-1:0] data_q,
	output logic                               valid_q,
	output logic                               tail
);

	// last occupied cell of the row
	assign tail = valid_q && !next_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_r) begin
			valid_q <= prev_valid;
		end else if (ctl.shift_l) begin
			valid_q <= next_valid;
		end else if (ctl.push_b && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end else if (ctl.pop_b && tail) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_r) begin
			data_q <= prev_data;
		end else if (ctl.shift_l) begin
			data_q <= next_data;
		end else if (ctl.push_b && !valid_q && prev_valid) begin
			data_q <= ctl.word;
		end
	end

endmodule

`default_nettype wire

// File: design/bounded_deque_top.sv
// bounded double-ended queue of signed words, built as a row of shifting cells
// depends on bdq_pkg and bdq_cell
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+------------------
//  s_      | in  | value[31:0]                                 | operation[1:0]
//  m_      | out | popped_value[31:0], item_count_out[36:32], 0 | status[1:0]
//
// the cell row updates at the edge that accepts the input beat, and the result
// lands in the output register at the same edge
// the front of the queue always sits in cell 0; the back is the last occupied cell
// reset clears the occupied flags and the count, stored words are left as they are
// input is taken while the output register is empty or being drained, so a
// stalled output holds at most one finished result and stops the input
`default_nettype none

module bounded_deque_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [bdq_pkg::S_DATA_W-1:0] s_tdata,   // value
	input  wire logic [bdq_pkg::OP_W-1:0]     s_tuser,   // operation
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [bdq_pkg::M_DATA_W-1:0] m_tdata,   // popped_value, item_count_out, zero pad
	output logic      [bdq_pkg::STATUS_W-1:0] m_tuser    // status
);

	localparam int DW = bdq_pkg::DATA_WIDTH;
	localparam int N  = bdq_pkg::DEPTH;

	// handshake and decode
	logic               accept;
	bdq_pkg::op_t       op;
	logic [DW-1:0]      word;
	logic               full;
	logic               empty;
	logic [bdq_pkg::CNT_W-1:0] count_q;
	logic [bdq_pkg::CNT_W-1:0] count_nxt;

	// cell row
	bdq_pkg::cell_ctl_t ctl;
	logic [DW-1:0]      cell_data [N];
	logic [N-1:0]       cell_valid;
	logic [N-1:0]       cell_tail;
	logic [DW-1:0]      back_word;

	// result
	logic [DW-1:0]       popped;
	bdq_pkg::status_t    status;
	logic                m_tvalid_q;
	logic [bdq_pkg::VALUE_W-1:0] popped_q;
	logic [bdq_pkg::COUNT_W-1:0] count_out_q;
	bdq_pkg::status_t    status_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = bdq_pkg::op_t'(s_tuser);
	assign word     = s_tdata[DW-1:0];
	assign full     = (count_q == bdq_pkg::CNT_W'(N));
	assign empty    = (count_q == '0);

	// one control word fans out to the whole row
	always_comb begin
		ctl         = '0;
		ctl.word    = word;
		ctl.shift_r = accept && (op == bdq_pkg::OP_PUSH_FRONT) && !full;
		ctl.push_b  = accept && (op == bdq_pkg::OP_PUSH_BACK)  && !full;
		ctl.shift_l = accept && (op == bdq_pkg::OP_POP_FRONT)  && !empty;
		ctl.pop_b   = accept && (op == bdq_pkg::OP_POP_BACK)   && !empty;
	end

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic [DW-1:0] prev_d;
			logic          prev_v;
			logic [DW-1:0] next_d;
			logic          next_v;

			if (gi == 0) begin : g_head
				// cell 0 sees the incoming word as its left neighbor
				assign prev_d = word;
				assign prev_v = 1'b1;
			end else begin : g_body
				assign prev_d = cell_data[gi-1];
				assign prev_v = cell_valid[gi-1];
			end

			if (gi == N - 1) begin : g_end
				assign next_d = '0;
				assign next_v = 1'b0;
			end else begin : g_mid
				assign next_d = cell_data[gi+1];
				assign next_v = cell_valid[gi+1];
			end

			bdq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_data  (prev_d),
				.prev_valid (prev_v),
				.next_data  (next_d),
				.next_valid (next_v),
				.data_q     (cell_data[gi]),
				.valid_q    (cell_valid[gi]),
				.tail       (cell_tail[gi])
			);
		end
	endgenerate

	// at most one cell flags itself as the tail, so an or over the row picks it
	always_comb begin
		back_word = '0;
		for (int i = 0; i < N; i++) begin
			back_word = back_word | (cell_tail[i] ? cell_data[i] : '0);
		end
	end

	// result and next count
	always_comb begin
		popped    = '0;
		status    = bdq_pkg::ST_OK;
		count_nxt = count_q;
		unique case (op) inside
			bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status = bdq_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			bdq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status = bdq_pkg::ST_EMPTY;
				end else begin
					popped    = cell_data[0];
					count_nxt = count_q - 1'b1;
				end
			end
			bdq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status = bdq_pkg::ST_EMPTY;
				end else begin
					popped    = back_word;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status = bdq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q    <= bdq_pkg::VALUE_W'(popped);
			count_out_q <= bdq_pkg::COUNT_W'(count_nxt);
			status_q    <= status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(bdq_pkg::M_DATA_W - bdq_pkg::VALUE_W - bdq_pkg::COUNT_W){1'b0}},
		count_out_q, popped_q};
	assign m_tuser  = status_q;

	// occupied cells always form an unbroken run from the front
	a_row_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((({1'b0, cell_valid} + (N+1)'(1)) & {1'b0, cell_valid}) == '0))
		else $error("occupied cells not contiguous from the front");

	// the count tracks the number of occupied cells
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(cell_valid) == int'(count_q)))
		else $error("count differs from occupied cells");

	// a full status is only reported when the row was full at acceptance
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status == bdq_pkg::ST_FULL) |=> (count_q == bdq_pkg::CNT_W'(N)))
		else $error("full status without a full row");

	// an empty status leaves the row empty
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status == bdq_pkg::ST_EMPTY) |=> (cell_valid == '0))
		else $error("empty status with occupied cells");

endmodule

`default_nettype wire

// File: tb/tb_bounded_deque_top.sv
// testbench for bounded_deque_top: directed and random deque operations on the input stream
// every result beat is checked against a ring-buffer model held in a small scoreboard class
// depends on bdq_pkg and the bounded_deque_top design

module tb_bounded_deque_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS  = 344;

	// one expected result beat, split into its fields
	typedef struct {
		logic [VALUE_W-1:0] popped;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} op_result_t;

	// ring-buffer model of the deque plus the queue of results still owed by the block
	class deque_scoreboard;
		logic [DATA_WIDTH-1:0] slots [DEPTH];
		int unsigned head;   // slot of the front entry
		int unsigned tail;   // slot one past the back entry
		int unsigned held;   // entries in the deque
		op_result_t  op_results [$];
		int unsigned errors;

		function new();
			head   = 0;
			tail   = 0;
			held   = 0;
			errors = 0;
		endfunction

		// apply one accepted operation to the model and queue the result it owes
		function void note_op(op_t op, logic [VALUE_W-1:0] value);
			op_result_t res;
			res.popped = '0;
			res.status = ST_OK;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (held >= DEPTH) begin
						res.status = ST_FULL;
					end else if (op == OP_PUSH_FRONT) begin
						head = (head == 0) ? DEPTH - 1 : head - 1;
						slots[head] = value[DATA_WIDTH-1:0];
						// first entry: back points just past it
						if (held == 0)
							tail = (head + 1) % DEPTH;
						held++;
					end else begin
						// first entry: front lands on it
						if (held == 0)
							head = tail;
						slots[tail] = value[DATA_WIDTH-1:0];
						tail = (tail + 1) % DEPTH;
						held++;
					end
				end
				default: begin
					if (held == 0) begin
						res.status = ST_EMPTY;
					end else if (op == OP_POP_FRONT) begin
						res.popped = VALUE_W'(slots[head]);
						head = (head + 1) % DEPTH;
						held--;
					end else begin
						tail = (tail == 0) ? DEPTH - 1 : tail - 1;
						res.popped = VALUE_W'(slots[tail]);
						held--;
					end
				end
			endcase
			res.count = held[COUNT_W-1:0];
			op_results.push_back(res);
		endfunction

		// compare one result beat with the oldest owed result
		function void check_result(logic [M_DATA_W-1:0] data, logic [STATUS_W-1:0] user);
			op_result_t         exp;
			logic [VALUE_W-1:0] popped;
			logic [COUNT_W-1:0] count;
			if (op_results.size() == 0) begin
				$error("result beat with nothing owed: tdata %h tuser %h", data, user);
				errors++;
			end else begin
				exp    = op_results.pop_front();
				popped = data[VALUE_W-1:0];
				count  = data[VALUE_W +: COUNT_W];
				if (popped !== exp.popped) begin
					$error("popped_value: expected %h, got %h", exp.popped, popped);
					errors++;
				end
				if (user !== exp.status) begin
					$error("status: expected %s, got %0d", exp.status.name(), user);
					errors++;
				end
				if (count !== exp.count) begin
					$error("item_count_out: expected %0d, got %0d", exp.count, count);
					errors++;
				end
				if (data[M_DATA_W-1:VALUE_W+COUNT_W] !== '0) begin
					$error("tdata pad: expected 0, got %h", data[M_DATA_W-1:VALUE_W+COUNT_W]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata  = '0;   // value
	logic [OP_W-1:0]       s_tuser  = '0;   // operation
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;         // popped_value, item_count_out, zero pad
	logic [STATUS_W-1:0]   m_tuser;         // status

	deque_scoreboard sb = new();

	int unsigned send_idle_pct  = 0;   // chance the sender holds back a cycle
	int unsigned recv_stall_pct = 0;   // chance the receiver drops tready
	int unsigned cycles         = 0;

	bounded_deque_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: tready drops at the current stall rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// one input beat: random idle cycles first, then hold valid until the block takes it
	task automatic send_op(op_t op, logic [VALUE_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_op(op, value);
	endtask

	// word to push, leaning on the signed extremes now and then
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// corner cases: empty pops, single entry in and out from opposite ends, fill, full pushes
	task automatic run_directed();
		send_op(OP_POP_FRONT, 32'h1234_5678);   // empty, value must be ignored
		send_op(OP_POP_BACK, '1);
		send_op(OP_PUSH_FRONT, 32'h8000_0000);  // lone entry pushed at the front
		send_op(OP_POP_BACK, '0);               // ... and taken from the back
		send_op(OP_PUSH_BACK, 32'h7fff_ffff);   // lone entry pushed at the back
		send_op(OP_POP_FRONT, '1);              // ... and taken from the front
		for (int i = 0; i < DEPTH; i++)
			send_op(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, (i == 0) ? '1 : pick_value());
		send_op(OP_PUSH_FRONT, 32'hdead_beef);  // full: word dropped
		send_op(OP_PUSH_BACK, 32'h0bad_f00d);
	endtask

	// random walk; the push bias changes every few dozen beats so the deque
	// swings between empty and full
	task automatic run_random(int unsigned count);
		int unsigned push_pct;
		logic        is_push;
		logic        at_front;
		op_t         op;
		push_pct = 50;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			is_push  = ($urandom_range(0, 99) < push_pct);
			at_front = $urandom_range(0, 1);
			if (is_push)
				op = at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = at_front ? OP_POP_FRONT : OP_POP_BACK;
			send_op(op, pick_value());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int phase = 0; phase < 4; phase++) begin
			// idle mix per phase: none, sender only, receiver only, both
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct  = 24;
					recv_stall_pct = 24;
				end
			endcase
			run_random(PHASE_ITEMS);
			// hold the input off until every owed result has come out
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while (sb.op_results.size() != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
